// ===== hw/rtl/cintp_pkg.sv =====
// Shared types and constants for the curve interpolation unit.
`default_nettype none

package cintp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PARAM_W   = 17;
	localparam int POINT_W   = 32;
	localparam int WGT_W     = 22;
	localparam int PROD_W    = WGT_W + POINT_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int TOTAL_W   = PROD_W + 2;
	localparam int RND_W     = TOTAL_W - FRAC_BITS - 1;

	localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1 << FRAC_BITS);

	typedef enum logic [1:0] {
		CM_CATMULL = 2'd0,
		CM_HERMITE = 2'd1,
		CM_LINEAR  = 2'd2,
		CM_BARY    = 2'd3
	} curve_mode_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] point_a;
		logic signed [POINT_W-1:0] point_b;
		logic signed [POINT_W-1:0] point_c;
		logic signed [POINT_W-1:0] point_d;
		logic [PARAM_W-1:0]        param_s;
		logic [PARAM_W-1:0]        weight_g;
	} req_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] result_value;
		logic                      saturated;
	} rsp_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] point_a;
		logic signed [POINT_W-1:0] point_b;
		logic signed [POINT_W-1:0] point_c;
		logic signed [POINT_W-1:0] point_d;
		logic signed [WGT_W-1:0]   wa;
		logic signed [WGT_W-1:0]   wb;
		logic signed [WGT_W-1:0]   wc;
		logic signed [WGT_W-1:0]   wd;
	} basis_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cintp_basis.sv =====
// Basis weight pipeline: parameter clamp, square, cube and weight forming.
`default_nettype none

module cintp_basis
	import cintp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        req_valid,
	input  wire req_t        req_data,
	input  wire curve_mode_t mode,
	output logic             valid_s4,
	output basis_t           basis_s4
);

	logic                valid_s1, valid_s2, valid_s3;
	req_t                pts_s1, pts_s2, pts_s3;
	curve_mode_t         mode_s1, mode_s2, mode_s3, mode_s4;
	logic [PARAM_W-1:0]  s_s1, g_s1, s_s2, g_s2, s_s3, g_s3;
	logic [PARAM_W-1:0]  ss_s2, ss_s3, sss_s3;
	logic [2*PARAM_W-1:0] sq_prod, cube_prod;
	logic [PARAM_W-1:0]  s_clamp, g_clamp;
	logic signed [WGT_W-1:0] sx, gx, ssx, sssx, onex;
	logic signed [WGT_W-1:0] wa, wb, wc, wd;

	assign s_clamp   = (req_data.param_s > PARAM_ONE) ? PARAM_ONE : req_data.param_s;
	assign g_clamp   = (req_data.weight_g > PARAM_ONE) ? PARAM_ONE : req_data.weight_g;
	assign sq_prod   = (2*PARAM_W)'(s_s1) * (2*PARAM_W)'(s_s1);
	assign cube_prod = (2*PARAM_W)'(s_s2) * (2*PARAM_W)'(ss_s2);

	assign sx   = $signed(WGT_W'(s_s3));
	assign gx   = $signed(WGT_W'(g_s3));
	assign ssx  = $signed(WGT_W'(ss_s3));
	assign sssx = $signed(WGT_W'(sss_s3));
	assign onex = $signed(WGT_W'(PARAM_ONE));

	always_comb begin
		unique case (mode_s3)
			CM_CATMULL: begin
				wa = WGT_W'(-sssx + 2 * ssx - sx);
				wb = WGT_W'(3 * sssx - 5 * ssx + 2 * onex);
				wc = WGT_W'(-3 * sssx + 4 * ssx + sx);
				wd = sssx - ssx;
			end
			CM_HERMITE: begin
				wa = WGT_W'(4 * sssx - 6 * ssx + 2 * onex);
				wb = WGT_W'(2 * (sssx - 2 * ssx + sx));
				wc = WGT_W'(-4 * sssx + 6 * ssx);
				wd = WGT_W'(2 * (sssx - ssx));
			end
			CM_LINEAR: begin
				wa = WGT_W'(2 * (onex - sx));
				wb = WGT_W'(2 * sx);
				wc = '0;
				wd = '0;
			end
			default: begin
				wa = WGT_W'(2 * (onex - sx - gx));
				wb = WGT_W'(2 * sx);
				wc = WGT_W'(2 * gx);
				wd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pts_s1  <= req_data;
			mode_s1 <= mode;
			s_s1    <= s_clamp;
			g_s1    <= g_clamp;

			pts_s2  <= pts_s1;
			mode_s2 <= mode_s1;
			s_s2    <= s_s1;
			g_s2    <= g_s1;
			ss_s2   <= sq_prod[FRAC_BITS+PARAM_W-1:FRAC_BITS];

			pts_s3  <= pts_s2;
			mode_s3 <= mode_s2;
			s_s3    <= s_s2;
			g_s3    <= g_s2;
			ss_s3   <= ss_s2;
			sss_s3  <= cube_prod[FRAC_BITS+PARAM_W-1:FRAC_BITS];

			mode_s4          <= mode_s3;
			basis_s4.point_a <= pts_s3.point_a;
			basis_s4.point_b <= pts_s3.point_b;
			basis_s4.point_c <= pts_s3.point_c;
			basis_s4.point_d <= pts_s3.point_d;
			basis_s4.wa      <= wa;
			basis_s4.wb      <= wb;
			basis_s4.wc      <= wc;
			basis_s4.wd      <= wd;
		end
	end

	// Interpolating bases form a partition of unity (weights are kept at twice their value).
	a_catmull_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && mode_s4 == CM_CATMULL |->
		(24'(basis_s4.wa) + 24'(basis_s4.wb) + 24'(basis_s4.wc) + 24'(basis_s4.wd))
		== 24'(2 * PARAM_ONE))
		else $error("Catmull-Rom weights do not sum to one");

	a_hermite_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && mode_s4 == CM_HERMITE |->
		(24'(basis_s4.wa) + 24'(basis_s4.wc)) == 24'(2 * PARAM_ONE))
		else $error("Hermite point weights do not sum to one");

	a_linear_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && mode_s4 == CM_LINEAR |->
		(24'(basis_s4.wa) + 24'(basis_s4.wb)) == 24'(2 * PARAM_ONE)
		&& basis_s4.wc == '0 && basis_s4.wd == '0)
		else $error("Linear weights malformed");

endmodule

`default_nettype wire

// ===== hw/rtl/cintp_mac.sv =====
// Weighted sum pipeline: four products, pair sums, rounding and saturation.
`default_nettype none

module cintp_mac
	import cintp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   valid_s4,
	input  wire basis_t basis_s4,
	output logic        valid_s7,
	output rsp_t        rsp_s7
);

	localparam logic signed [TOTAL_W-1:0] ROUND_HALF = TOTAL_W'(1 << FRAC_BITS);
	localparam logic signed [RND_W-1:0]   RES_MAX    = RND_W'(64'sd2147483647);
	localparam logic signed [RND_W-1:0]   RES_MIN    = -RND_W'(64'sd2147483648);

	logic                      valid_s5, valid_s6;
	logic signed [PROD_W-1:0]  pa_s5, pb_s5, pc_s5, pd_s5;
	logic signed [PAIR_W-1:0]  ab_s6, cd_s6;
	logic signed [TOTAL_W-1:0] total;
	logic signed [RND_W-1:0]   rnd;
	rsp_t                      rsp_next;

	assign total = TOTAL_W'(ab_s6) + TOTAL_W'(cd_s6) + ROUND_HALF;
	assign rnd   = RND_W'(total >>> (FRAC_BITS + 1));

	always_comb begin
		if (rnd > RES_MAX) begin
			rsp_next.result_value = POINT_W'(RES_MAX);
			rsp_next.saturated    = 1'b1;
		end else if (rnd < RES_MIN) begin
			rsp_next.result_value = POINT_W'(RES_MIN);
			rsp_next.saturated    = 1'b1;
		end else begin
			rsp_next.result_value = POINT_W'(rnd);
			rsp_next.saturated    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s5  <= PROD_W'(basis_s4.wa) * PROD_W'(basis_s4.point_a);
			pb_s5  <= PROD_W'(basis_s4.wb) * PROD_W'(basis_s4.point_b);
			pc_s5  <= PROD_W'(basis_s4.wc) * PROD_W'(basis_s4.point_c);
			pd_s5  <= PROD_W'(basis_s4.wd) * PROD_W'(basis_s4.point_d);
			ab_s6  <= PAIR_W'(pa_s5) + PAIR_W'(pb_s5);
			cd_s6  <= PAIR_W'(pc_s5) + PAIR_W'(pd_s5);
			rsp_s7 <= rsp_next;
		end
	end

	// A clipped result sits exactly at one end of the range.
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && rsp_s7.saturated |->
		(rsp_s7.result_value == 32'sh7fffffff || rsp_s7.result_value == 32'sh80000000))
		else $error("Saturated result not at a range limit");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(rsp_s7) && $stable(valid_s7) && $stable(ab_s6) && $stable(cd_s6))
		else $error("Pipeline changed while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/curve_interpolation_unit.sv =====
// A request accepted at one clock edge is registered through stages s1 to s7 before its result shows on rsp_valid.
// Throughput: one request per cycle while rsp_stall does not freeze it; the seven-stage pipeline advances as a whole.
// The pipeline freezes only while a result is shown and rsp_stall is high.
// Asynchronous reset clears every stage valid bit and sets curve_mode to Catmull-Rom.
// Top level of the curve interpolation unit.
`default_nettype none

module curve_interpolation_unit
	import cintp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_t       req_data,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp_data,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata
);

	curve_mode_t curve_mode_q;
	logic        adv;
	logic        valid_s4;
	basis_t      basis_s4;

	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= CM_CATMULL;
		end else if (cfg_we) begin
			curve_mode_q <= curve_mode_t'(cfg_wdata);
		end
	end

	cintp_basis u_basis (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (req_valid),
		.req_data  (req_data),
		.mode      (curve_mode_q),
		.valid_s4  (valid_s4),
		.basis_s4  (basis_s4)
	);

	cintp_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s4 (valid_s4),
		.basis_s4 (basis_s4),
		.valid_s7 (rsp_valid),
		.rsp_s7   (rsp_data)
	);

endmodule

`default_nettype wire

// ===== tb/curve_interp_checker.sv =====
// Checker for the curve interpolation unit: predicts each result and compares it with the output.
module cintp_result_checker
	import cintp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  req_t       req_data,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  rsp_t       rsp_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	output int         fail_count,
	output int         pending
);

	localparam longint POS_LIMIT = 64'sd2147483647;
	localparam longint NEG_LIMIT = -64'sd2147483648;

	curve_mode_t active_mode;
	rsp_t        expected_q[$];
	rsp_t        want;
	int          mismatches;

	function automatic rsp_t predict_component(input req_t r, input curve_mode_t m);
		longint one = longint'(1) << FRAC_BITS;
		longint pa, pb, pc, pd, s, g, ss, sss;
		longint wa, wb, wc, wd, acc, rounded;
		rsp_t   o;
		pa = longint'($signed(r.point_a));
		pb = longint'($signed(r.point_b));
		pc = longint'($signed(r.point_c));
		pd = longint'($signed(r.point_d));
		s = (r.param_s > PARAM_ONE) ? one : longint'(r.param_s);
		g = (r.weight_g > PARAM_ONE) ? one : longint'(r.weight_g);
		ss = (s * s) >>> FRAC_BITS;
		sss = (s * ss) >>> FRAC_BITS;
		// Weights are kept at twice their value so that the halves stay exact.
		case (m)
			CM_CATMULL: begin
				wa = -sss + 2 * ss - s;
				wb = 3 * sss - 5 * ss + 2 * one;
				wc = -3 * sss + 4 * ss + s;
				wd = sss - ss;
			end
			CM_HERMITE: begin
				wa = 4 * sss - 6 * ss + 2 * one;
				wb = 2 * (sss - 2 * ss + s);
				wc = -4 * sss + 6 * ss;
				wd = 2 * (sss - ss);
			end
			CM_LINEAR: begin
				wa = 2 * (one - s);
				wb = 2 * s;
				wc = 0;
				wd = 0;
			end
			default: begin
				wa = 2 * (one - s - g);
				wb = 2 * s;
				wc = 2 * g;
				wd = 0;
			end
		endcase
		acc = wa * pa + wb * pb + wc * pc + wd * pd;
		rounded = (acc + one) >>> (FRAC_BITS + 1);
		o.saturated = 1'b0;
		if (rounded > POS_LIMIT) begin
			rounded = POS_LIMIT;
			o.saturated = 1'b1;
		end else if (rounded < NEG_LIMIT) begin
			rounded = NEG_LIMIT;
			o.saturated = 1'b1;
		end
		o.result_value = rounded[POINT_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			active_mode = CM_CATMULL;
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_q.push_back(predict_component(req_data, active_mode));
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got value %0d saturated %0b",
						$time, $signed(rsp_data.result_value), rsp_data.saturated);
				end else begin
					want = expected_q.pop_front();
					if (rsp_data.result_value !== want.result_value) begin
						mismatches++;
						$display("%0t: result_value mismatch, expected %0d, got %0d", $time,
							$signed(want.result_value), $signed(rsp_data.result_value));
					end
					if (rsp_data.saturated !== want.saturated) begin
						mismatches++;
						$display("%0t: saturated mismatch, expected %0b, got %0b", $time,
							want.saturated, rsp_data.saturated);
					end
				end
			end
			if (cfg_we) begin
				active_mode = curve_mode_t'(cfg_wdata);
			end
			pending <= expected_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== tb/tb_curve_interpolation_unit.sv =====
// Testbench top for the curve interpolation unit: clock, reset, stimulus and verdict.
module tb_curve_interpolation_unit;
	import cintp_pkg::*;

	localparam logic signed [POINT_W-1:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [POINT_W-1:0] MINV = 32'sh8000_0000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 163;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req_data = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp_data;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	int         fail_count;
	int         pending;
	int         stall_left;
	int unsigned stall_pick;

	curve_mode_t directed_order[4] = '{CM_CATMULL, CM_HERMITE, CM_LINEAR, CM_BARY};
	curve_mode_t random_order[4] = '{CM_CATMULL, CM_BARY, CM_HERMITE, CM_LINEAR};

	curve_interpolation_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	cintp_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #10 clk = ~clk;

	// Receiver stalls come in short bursts, occasional long ones, and calm stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 50) begin
				rsp_stall <= 1'b0;
			end else if (stall_pick < 80) begin
				rsp_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else if (stall_pick < 83) begin
				rsp_stall <= 1'b1;
				stall_left <= $urandom_range(10, 40);
			end else begin
				rsp_stall <= 1'b0;
				stall_left <= $urandom_range(5, 60);
			end
		end
	end

	function automatic logic signed [POINT_W-1:0] random_point();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom;
			6, 7, 8: return $urandom_range(0, 2 ** 21) - 2 ** 20;
			default: begin
				case ($urandom_range(0, 3))
					0: return MAXV;
					1: return MINV;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		r.point_a = random_point();
		r.point_b = random_point();
		r.point_c = random_point();
		r.point_d = random_point();
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			r.param_s = $urandom_range(0, 17'h1FFFF);
		end else if (pick == 1) begin
			r.param_s = PARAM_ONE;
		end else if (pick == 2) begin
			r.param_s = '0;
		end else begin
			r.param_s = $urandom_range(0, PARAM_ONE);
		end
		if ($urandom_range(0, 3) == 0) begin
			r.weight_g = $urandom_range(0, 17'h1FFFF);
		end else if (r.param_s <= PARAM_ONE) begin
			r.weight_g = $urandom_range(0, PARAM_ONE - r.param_s);
		end else begin
			r.weight_g = $urandom_range(0, PARAM_ONE);
		end
		return r;
	endfunction

	function automatic req_t directed_request(input int k);
		req_t r;
		case (k)
			0: r = '{MAXV, MAXV, MAXV, MAXV, 17'd0, 17'd0};
			1: r = '{MINV, MINV, MINV, MINV, PARAM_ONE, PARAM_ONE};
			2: r = '{MINV, MAXV, MAXV, MINV, 17'd32768, 17'd32768};
			3: r = '{MAXV, MINV, MINV, MAXV, 17'd49152, 17'd0};
			4: r = '{32'sd1, -32'sd1, 32'sh0001_0000, -32'sh0001_0000, 17'h1FFFF, 17'h1FFFF};
			default: r = '{32'sd0, 32'sd1, -32'sd1, 32'sd3, 17'd32768, 17'd16384};
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(input req_t r, input bit no_gaps);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_data <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_mode(input curve_mode_t m);
		wait_drained();
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		bit no_gaps;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int mi = 0; mi < 4; mi++) begin
			if (mi > 0) set_mode(directed_order[mi]);
			for (int k = 0; k < 6; k++) begin
				send_request(directed_request(k), 1'b0);
			end
		end
		for (int ph = 0; ph < PHASES; ph++) begin
			set_mode(ph < 4 ? random_order[ph] : curve_mode_t'($urandom_range(0, 3)));
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 299) == 0) wait_drained();
				send_request(random_request(), no_gaps);
			end
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS curve_interpolation_unit");
		end else begin
			$display("FAIL curve_interpolation_unit");
		end
		$finish;
	end

	initial begin : watchdog
		#20000000;
		$display("FAIL curve_interpolation_unit");
		$finish;
	end

endmodule
